// File: rtl/core/fgnp_pkg.sv
// package for the fractal gradient noise pixel block
// item structs, register indexes, gradient function; no dependencies
package fgnp_pkg;

   localparam int unsigned MaxOctavesDefault   = 8;
   localparam int unsigned TableEntriesDefault = 256;

   localparam logic [2:0] CsrOctaveCount = 3'd0;
   localparam logic [2:0] CsrStep        = 3'd1;
   localparam logic [2:0] CsrLacunarity  = 3'd2;
   localparam logic [2:0] CsrPersistence = 3'd3;
   localparam logic [2:0] CsrAmplitude   = 3'd4;
   localparam logic [2:0] CsrHorizOffset = 3'd5;
   localparam logic [2:0] CsrVertOffset  = 3'd6;

   localparam logic OpEvaluate   = 1'b0;
   localparam logic OpTableWrite = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [15:0] pixel_x;
      logic [15:0] pixel_y;
      logic [7:0]  table_index;
      logic [7:0]  table_value;
   } req_item_type;

   typedef struct packed {
      logic [7:0]         gray_level;
      logic signed [23:0] noise_sum;
   } rsp_item_type;

   // influence of gradient g on offset (dx, dy), Q24 signed
   function automatic logic signed [26:0] grad_dot(input logic [2:0] g,
                                                   input logic signed [25:0] dx,
                                                   input logic signed [25:0] dy);
      logic signed [26:0] x;
      logic signed [26:0] y;
      begin
         x = 27'(dx);
         y = 27'(dy);
         case (g)
            3'd0: grad_dot = x + y;
            3'd1: grad_dot = y - x;
            3'd2: grad_dot = x - y;
            3'd3: grad_dot = -x - y;
            3'd4: grad_dot = x;
            3'd5: grad_dot = -x;
            3'd6: grad_dot = y;
            default: grad_dot = -y;
         endcase
      end
   endfunction

endpackage

// File: rtl/core/fgnp_fade.sv
// quintic fade of a Q0.24 fraction, registered over four stages
// no package dependency
module fgnp_fade (
   input  logic        clock,
   input  logic [23:0] frac,
   output logic [24:0] fade
);
   logic [23:0] t_ff, t_in;
   logic [23:0] t1_ff;
   logic [23:0] t2_ff;
   logic [47:0] sq;
   logic [23:0] t3_ff;
   logic [47:0] cube;
   logic [28:0] poly_ff;
   logic [28:0] poly_in;
   logic [52:0] prod;
   logic [24:0] fade_ff;

   assign t_in = frac;
   assign sq   = 48'(t_ff) * 48'(t_ff);
   assign cube = 48'(t2_ff) * 48'(t1_ff);
   // 6*t2 - 15*t + 10, never negative
   assign poly_in = 29'(6) * 29'(t2_ff) + (29'd10 << 24) - 29'(15) * 29'(t1_ff);
   assign prod = 53'(t3_ff) * 53'(poly_ff);

   always_ff @(posedge clock) begin
      t_ff    <= t_in;
      t1_ff   <= t_ff;
      t2_ff   <= sq[47:24];
      t3_ff   <= cube[47:24];
      poly_ff <= poly_in;
      fade_ff <= prod[48:24];
   end
   assign fade = fade_ff;
endmodule

// File: rtl/core/fgnp_perm_mem.sv
// 256 x 8 permutation memory, one write and one read per cycle
// registered read data; no package dependency
module fgnp_perm_mem #(
   parameter int unsigned Entries = 256
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(Entries)-1:0] wr_addr,
   input  logic [7:0]                 wr_data,
   input  logic [$clog2(Entries)-1:0] rd_addr,
   output logic [7:0]                 rd_data
);
   logic [7:0] mem_ff [Entries];
   logic [7:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

// File: rtl/core/fractal_gradient_noise_pixel.sv
// top level of the fractal gradient noise pixel block
// uses fgnp_pkg, fgnp_perm_mem and fgnp_fade
//
// One pixel item gives one result item: octave_count octaves (capped at
// MAX_OCTAVES) of 2D gradient noise summed and saturated to Q8.16, plus a gray
// byte. A table-write item stores one permutation entry as it is accepted and gives
// no result; all 256 entries must be loaded before pixels are sent. Octaves
// run one after another through a sequencer around a permutation memory with a
// single read port: each octave does six dependent table reads (two row lookups,
// four corner lookups), then blending, and a pixel holds the block until its
// result is loaded. The result sits in an output register, so the next item is
// taken while it waits.
module fractal_gradient_noise_pixel
   import fgnp_pkg::*;
#(
   parameter int unsigned MAX_OCTAVES   = MaxOctavesDefault,
   parameter int unsigned TABLE_ENTRIES = TableEntriesDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  fgnp_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output fgnp_pkg::rsp_item_type rsp_item,
   input  logic                  csr_write_enable,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_write_data
);
   localparam int unsigned AW = $clog2(TABLE_ENTRIES);
   localparam int unsigned CW = $clog2(MAX_OCTAVES + 1);

   typedef enum logic [3:0] {
      IDLE, SCALE, ROW0, ROW1, C00, C10, C01, C11, FADEW, LERPX, LERPY,
      ACCUM, UPDATE, FINISH, HOLD
   } state_type;

   // configuration registers
   logic [3:0]  oct_ff;
   logic [31:0] step_cfg_ff;
   logic [4:0]  lac_ff;
   logic [15:0] pers_ff;
   logic [15:0] amp_cfg_ff;
   logic signed [15:0] hoff_ff;
   logic signed [15:0] voff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_ff      <= 4'd1;
         step_cfg_ff <= 32'd65536;
         lac_ff      <= 5'd2;
         pers_ff     <= 16'd16384;
         amp_cfg_ff  <= 16'd4096;
         hoff_ff     <= '0;
         voff_ff     <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CsrOctaveCount: oct_ff      <= csr_write_data[3:0];
            CsrStep:        step_cfg_ff <= csr_write_data;
            CsrLacunarity:  lac_ff      <= csr_write_data[4:0];
            CsrPersistence: pers_ff     <= csr_write_data[15:0];
            CsrAmplitude:   amp_cfg_ff  <= csr_write_data[15:0];
            CsrHorizOffset: hoff_ff     <= csr_write_data[15:0];
            CsrVertOffset:  voff_ff     <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   state_type   state_ff;
   logic [CW-1:0] left_ff;
   logic [31:0] px_ff, py_ff;          // pixel plus offset, 32-bit two's complement
   logic [31:0] step_ff;
   logic [15:0] amp_ff;
   logic [7:0]  cx_ff, cy_ff;
   logic [23:0] tx_ff, ty_ff;
   logic [7:0]  rowa_ff, rowb_ff;     // table[cx], table[cx+1]
   logic [2:0]  h00_ff, h10_ff, h01_ff;
   logic [3:0]  wait_ff;
   logic signed [26:0] i00_ff, i10_ff, i01_ff, i11_ff;
   logic signed [26:0] top_ff, bot_ff, noise_ff;
   logic signed [31:0] sum_ff;        // 8 octaves of at most 2^26 each fits
   logic        rsp_valid_ff;
   rsp_item_type rsp_ff;

   // memory port
   logic          mem_we;
   logic [AW-1:0] mem_raddr;
   logic [7:0]    mem_rdata;

   assign req_ready = (state_ff == IDLE);
   assign mem_we = req_valid && req_ready && req_item.operation == OpTableWrite;

   always_comb begin
      case (state_ff)
         ROW0:    mem_raddr = AW'(cx_ff);
         ROW1:    mem_raddr = AW'(cx_ff + 8'd1);
         C00:     mem_raddr = AW'(rowa_ff + cy_ff);
         C10:     mem_raddr = AW'(rowb_ff + cy_ff);
         C01:     mem_raddr = AW'(rowa_ff + cy_ff + 8'd1);
         default: mem_raddr = AW'(rowb_ff + cy_ff + 8'd1);
      endcase
   end

   fgnp_perm_mem #(.Entries(TABLE_ENTRIES)) u_mem (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(AW'(req_item.table_index)),
      .wr_data(req_item.table_value),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   // fades start when the fraction is known and come out of the registered fade pipes
   logic [24:0] fade_u, fade_v;
   fgnp_fade u_fade_x (.clock(clock), .frac(tx_ff), .fade(fade_u));
   fgnp_fade u_fade_y (.clock(clock), .frac(ty_ff), .fade(fade_v));

   // scaled coordinates
   logic [63:0] nx_full, ny_full;
   assign nx_full = 64'(px_ff) * 64'(step_ff);
   assign ny_full = 64'(py_ff) * 64'(step_ff);

   // shared-shape lerps: a + floor(f*(b-a)/2^24)
   logic signed [27:0] dtop, dbot, dy;
   logic signed [53:0] ptop, pbot, pfin;
   assign dtop = 28'(i10_ff) - 28'(i00_ff);
   assign dbot = 28'(i11_ff) - 28'(i01_ff);
   assign dy   = 28'(bot_ff) - 28'(top_ff);
   assign ptop = 54'(dtop) * $signed({29'd0, fade_u});
   assign pbot = 54'(dbot) * $signed({29'd0, fade_u});
   assign pfin = 54'(dy) * $signed({29'd0, fade_v});

   // octave term floor(n*amp/2^20)
   logic signed [43:0] term_full;
   assign term_full = 44'(noise_ff) * $signed({28'd0, amp_ff});

   // amplitude and step updates
   logic [31:0] amp_next_full;
   logic [36:0] step_next_full;
   assign amp_next_full  = 32'(amp_ff) * 32'(pers_ff);
   assign step_next_full = 37'(step_ff) * 37'(lac_ff);

   // output mapping
   logic signed [23:0] sat;
   logic signed [17:0] clip;
   logic [25:0]        gray_full;
   always_comb begin
      if (sum_ff > 32'sd8388607)       sat = 24'sd8388607;
      else if (sum_ff < -32'sd8388608) sat = -24'sd8388608;
      else                             sat = sum_ff[23:0];
      if (sat > 24'sd65536)       clip = 18'sd65536;
      else if (sat < -24'sd65536) clip = -18'sd65536;
      else                        clip = sat[17:0];
      // shifted clip runs 0 to 2^17, taken as unsigned
      gray_full = {8'd0, 18'(clip + 18'sd65536)} * 26'd255;
   end

   logic [2:0] hash;
   assign hash = mem_rdata[2:0];

   logic signed [25:0] fx, fy, fx1, fy1;
   assign fx  = $signed({2'b00, tx_ff});
   assign fy  = $signed({2'b00, ty_ff});
   assign fx1 = fx - 26'sd16777216;
   assign fy1 = fy - 26'sd16777216;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         left_ff      <= '0;
         wait_ff      <= '0;
      end else begin
         // FINISH reloads the result register itself
         if (rsp_valid_ff && rsp_ready && state_ff != FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_valid && req_ready && req_item.operation == OpEvaluate) begin
                  px_ff   <= 32'($signed({1'b0, req_item.pixel_x})) + 32'(hoff_ff);
                  py_ff   <= 32'($signed({1'b0, req_item.pixel_y})) + 32'(voff_ff);
                  step_ff <= step_cfg_ff;
                  amp_ff  <= amp_cfg_ff;
                  sum_ff  <= '0;
                  left_ff <= (32'(oct_ff) > MAX_OCTAVES) ? CW'(MAX_OCTAVES) : CW'(oct_ff);
                  state_ff <= (oct_ff == 4'd0) ? FINISH : SCALE;
               end
            end
            SCALE: begin
               cx_ff <= nx_full[31:24];
               cy_ff <= ny_full[31:24];
               tx_ff <= nx_full[23:0];
               ty_ff <= ny_full[23:0];
               state_ff <= ROW0;
            end
            ROW0: state_ff <= ROW1;
            ROW1: begin
               rowa_ff  <= mem_rdata;
               state_ff <= C00;
            end
            C00: begin
               rowb_ff  <= mem_rdata;
               state_ff <= C10;
            end
            C10: begin
               h00_ff   <= hash;
               state_ff <= C01;
            end
            C01: begin
               h10_ff   <= hash;
               state_ff <= C11;
            end
            C11: begin
               h01_ff   <= hash;
               wait_ff  <= '0;
               state_ff <= FADEW;
            end
            FADEW: begin
               if (wait_ff == 4'd0) begin
                  i11_ff <= grad_dot(hash, fx1, fy1);
                  i00_ff <= grad_dot(h00_ff, fx, fy);
                  i10_ff <= grad_dot(h10_ff, fx1, fy);
                  i01_ff <= grad_dot(h01_ff, fx, fy1);
               end
               wait_ff <= wait_ff + 4'd1;
               if (wait_ff == 4'd1) state_ff <= LERPX;
            end
            LERPX: begin
               top_ff   <= i00_ff + 27'(ptop >>> 24);
               bot_ff   <= i01_ff + 27'(pbot >>> 24);
               state_ff <= LERPY;
            end
            LERPY: begin
               noise_ff <= top_ff + 27'(pfin >>> 24);
               state_ff <= ACCUM;
            end
            ACCUM: begin
               sum_ff   <= sum_ff + 32'(term_full >>> 20);
               state_ff <= UPDATE;
            end
            UPDATE: begin
               step_ff <= step_next_full[31:0];
               amp_ff  <= (amp_next_full[31:15] > 17'd65535) ? 16'hFFFF
                                                              : amp_next_full[30:15];
               left_ff <= left_ff - CW'(1);
               state_ff <= (left_ff == CW'(1)) ? FINISH : SCALE;
            end
            FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.noise_sum  <= sat;
                  rsp_ff.gray_level <= gray_full[24:17];
                  rsp_valid_ff      <= 1'b1;
                  state_ff          <= IDLE;
               end
            end
            HOLD: state_ff <= IDLE;
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
endmodule

// File: tb/sv/fractal_gradient_noise_pixel_tb.sv
// testbench for the fractal gradient noise pixel block
// drives pixel and table-write items, predicts each result and checks it
// needs fgnp_pkg and fractal_gradient_noise_pixel
`timescale 1ns / 100ps

module fractal_gradient_noise_pixel_tb;
   import fgnp_pkg::*;

   localparam int unsigned OctaveCap = 8;
   localparam int unsigned CycleLimit = 2000000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_item;
   logic         csr_write_enable;
   logic [2:0]   csr_index;
   logic [31:0]  csr_write_data;

   // local copy of block state and registers
   logic [7:0]  perm_shadow [256];
   logic [3:0]  octaves_reg;
   logic [31:0] step_reg;
   logic [4:0]  lacunarity_reg;
   logic [15:0] persistence_reg;
   logic [15:0] amplitude_reg;
   logic signed [15:0] x_offset_reg;
   logic signed [15:0] y_offset_reg;

   rsp_item_type pending_pixels [$];
   int unsigned  mismatch_count;
   int unsigned  pixels_checked;
   int unsigned  table_writes;
   int unsigned  cycle_count;
   bit           idle_enable;

   fractal_gradient_noise_pixel u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // timeout watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // arithmetic shift is a floor for signed values
   function automatic longint fade_of(input longint t);
      longint t2;
      longint t3;
      t2 = (t * t) >>> 24;
      t3 = (t2 * t) >>> 24;
      return (t3 * (6 * t2 + (longint'(10) << 24) - 15 * t)) >>> 24;
   endfunction

   function automatic longint blend(input longint a, input longint b, input longint f);
      return a + ((f * (b - a)) >>> 24);
   endfunction

   function automatic longint corner_dot(input logic [7:0] cx, input logic [7:0] cy,
                                         input longint dx, input longint dy);
      logic [7:0] row;
      logic [2:0] g;
      row = perm_shadow[cx];
      g = perm_shadow[8'(row + cy)][2:0];
      case (g)
         3'd0: return dx + dy;
         3'd1: return dy - dx;
         3'd2: return dx - dy;
         3'd3: return -dx - dy;
         3'd4: return dx;
         3'd5: return -dx;
         3'd6: return dy;
         default: return -dy;
      endcase
   endfunction

   function automatic longint octave_noise(input logic [31:0] px, input logic [31:0] py,
                                           input logic [31:0] step);
      logic [31:0] nx;
      logic [31:0] ny;
      longint fx;
      longint fy;
      longint one;
      longint top;
      longint bottom;
      nx = px * step;
      ny = py * step;
      fx = longint'(nx[23:0]);
      fy = longint'(ny[23:0]);
      one = longint'(1) << 24;
      top = blend(corner_dot(nx[31:24], ny[31:24], fx, fy),
                  corner_dot(nx[31:24] + 8'd1, ny[31:24], fx - one, fy), fade_of(fx));
      bottom = blend(corner_dot(nx[31:24], ny[31:24] + 8'd1, fx, fy - one),
                     corner_dot(nx[31:24] + 8'd1, ny[31:24] + 8'd1, fx - one, fy - one),
                     fade_of(fx));
      return blend(top, bottom, fade_of(fy));
   endfunction

   function automatic rsp_item_type pixel_noise(input logic [15:0] x, input logic [15:0] y);
      rsp_item_type r;
      logic [31:0]  px;
      logic [31:0]  py;
      logic [31:0]  step;
      longint       amp;
      longint       sum;
      longint       c;
      int unsigned  count;
      px = 32'(int'(x) + int'(x_offset_reg));
      py = 32'(int'(y) + int'(y_offset_reg));
      count = (octaves_reg > OctaveCap) ? OctaveCap : octaves_reg;
      step = step_reg;
      amp = amplitude_reg;
      sum = 0;
      for (int unsigned k = 0; k < count; k++) begin
         sum += (octave_noise(px, py, step) * amp) >>> 20;
         step = step * 32'(lacunarity_reg);
         amp = (amp * longint'(persistence_reg)) >> 15;
         if (amp > 65535) amp = 65535;
      end
      if (sum > 8388607) sum = 8388607;
      if (sum < -8388608) sum = -8388608;
      c = sum;
      if (c > 65536) c = 65536;
      if (c < -65536) c = -65536;
      r.gray_level = 8'(((c + 65536) * 255) >> 17);
      r.noise_sum = 24'(sum);
      return r;
   endfunction

   // one write, then a wait with the enable low so back-to-back writes never overlap
   task automatic write_register(input logic [2:0] index, input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         CsrOctaveCount: octaves_reg = value[3:0];
         CsrStep:        step_reg = value;
         CsrLacunarity:  lacunarity_reg = value[4:0];
         CsrPersistence: persistence_reg = value[15:0];
         CsrAmplitude:   amplitude_reg = value[15:0];
         CsrHorizOffset: x_offset_reg = value[15:0];
         CsrVertOffset:  y_offset_reg = value[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // a gap drops valid; without one the next item follows directly
   task automatic idle_gap();
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // send one item; the prediction is made at acceptance
   task automatic send_item(input req_item_type item);
      idle_gap();
      req_valid <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (!req_ready);
      if (item.operation == OpTableWrite) begin
         perm_shadow[item.table_index] = item.table_value;
         table_writes++;
      end else
         pending_pixels.push_back(pixel_noise(item.pixel_x, item.pixel_y));
   endtask

   task automatic send_pixel(input logic [15:0] x, input logic [15:0] y);
      req_item_type item;
      item = '0;
      item.operation = OpEvaluate;
      item.pixel_x = x;
      item.pixel_y = y;
      send_item(item);
   endtask

   task automatic send_table_write(input logic [7:0] index, input logic [7:0] value);
      req_item_type item;
      item = '0;
      item.operation = OpTableWrite;
      item.table_index = index;
      item.table_value = value;
      item.pixel_x = 16'($urandom);   // ignored fields carry noise
      item.pixel_y = 16'($urandom);
      send_item(item);
   endtask

   // stop sending, wait for every pixel to come back, then for the tail
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // result side: random stalls, compare with oldest prediction
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (pending_pixels.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result gray %0d sum %0d",
                           rsp_item.gray_level, rsp_item.noise_sum);
            end else begin
               rsp_item_type want;
               want = pending_pixels.pop_front();
               pixels_checked++;
               if (want.gray_level !== rsp_item.gray_level ||
                   want.noise_sum !== rsp_item.noise_sum) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected gray %0d sum %0d, got gray %0d sum %0d",
                              want.gray_level, want.noise_sum,
                              rsp_item.gray_level, rsp_item.noise_sum);
               end
            end
         end
         if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // full table load, a random permutation
   task automatic test_table_load();
      logic [7:0] vals [256];
      for (int i = 0; i < 256; i++) vals[i] = 8'(i);
      vals.shuffle();
      for (int i = 0; i < 256; i++) send_table_write(8'(i), vals[i]);
   endtask

   // field extremes at reset settings, then register extremes
   task automatic test_directed();
      send_pixel(16'h0000, 16'h0000);
      send_pixel(16'hFFFF, 16'hFFFF);
      send_pixel(16'hFFFF, 16'h0000);
      send_pixel(16'h8000, 16'h7FFF);
      send_pixel(16'h1234, 16'h5678);
      drain();
      // zero octaves
      write_register(CsrOctaveCount, 32'd0);
      send_pixel(16'd7, 16'd9);
      drain();
      // octave count above the cap, growing amplitude, big sums saturate
      write_register(CsrOctaveCount, 32'd15);
      write_register(CsrPersistence, 32'hFFFF);
      write_register(CsrAmplitude, 32'hFFFF);
      write_register(CsrStep, 32'h0123_4567);
      write_register(CsrLacunarity, 32'd16);
      send_pixel(16'd3, 16'd5);
      send_pixel(16'hABCD, 16'h0101);
      send_pixel(16'd100, 16'd200);
      drain();
      // negative offsets, zero lacunarity, max step, zero persistence
      write_register(CsrHorizOffset, 32'h0000_8000);
      write_register(CsrVertOffset, 32'h0000_FFFF);
      write_register(CsrLacunarity, 32'd0);
      write_register(CsrStep, 32'hFFFF_FFFF);
      write_register(CsrPersistence, 32'd0);
      write_register(CsrOctaveCount, 32'd8);
      send_pixel(16'd0, 16'd0);
      send_pixel(16'd1, 16'd1);
      send_pixel(16'hFFFF, 16'h8000);
      drain();
      // maximum positive offset, lacunarity above sixteen, zero amplitude and step
      write_register(CsrHorizOffset, 32'h0000_7FFF);
      write_register(CsrVertOffset, 32'h0000_0001);
      write_register(CsrLacunarity, 32'd31);
      write_register(CsrAmplitude, 32'd0);
      write_register(CsrStep, 32'd0);
      send_pixel(16'd50, 16'd60);
      drain();
      // index beyond the list is ignored
      write_register(3'd7, 32'hFFFF_FFFF);
      write_register(CsrAmplitude, 32'd4096);
      write_register(CsrStep, 32'h0010_0000);
      write_register(CsrPersistence, 32'd16384);
      write_register(CsrLacunarity, 32'd2);
      send_pixel(16'd17, 16'd33);
      send_pixel(16'hFFFF, 16'hFFFF);
      drain();
   endtask

   // random phases: new settings, table rewrites now and then, mostly pixels
   task automatic test_random(input int unsigned phases, input int unsigned per_phase);
      for (int unsigned p = 0; p < phases; p++) begin
         write_register(CsrOctaveCount, ($urandom_range(0, 7) == 0) ?
                        32'($urandom_range(9, 15)) : 32'($urandom_range(0, 4)));
         write_register(CsrStep, $urandom);
         write_register(CsrLacunarity, 32'($urandom_range(0, 31)));
         write_register(CsrPersistence, 32'($urandom_range(0, 65535)));
         write_register(CsrAmplitude, 32'($urandom_range(0, 65535)));
         write_register(CsrHorizOffset, $urandom);
         write_register(CsrVertOffset, $urandom);
         for (int unsigned i = 0; i < per_phase; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_table_write(8'($urandom), 8'($urandom));
            else
               send_pixel(16'($urandom), 16'($urandom));
         end
         drain();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      csr_write_enable = 1'b0;
      csr_index = CsrOctaveCount;
      csr_write_data = '0;
      mismatch_count = 0;
      pixels_checked = 0;
      table_writes = 0;
      cycle_count = 0;
      idle_enable = 1'b1;
      octaves_reg = 4'd1;
      step_reg = 32'd65536;
      lacunarity_reg = 5'd2;
      persistence_reg = 16'd16384;
      amplitude_reg = 16'd4096;
      x_offset_reg = '0;
      y_offset_reg = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_table_load();
      test_directed();
      test_random(20, 50);
      idle_enable = 1'b0;   // last part runs at full pressure
      test_random(3, 30);
      drain();
      $display("checked %0d pixel results, %0d table writes, over many register settings",
               pixels_checked, table_writes);
      if (mismatch_count == 0 && pending_pixels.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
